// ===== design/jfh_pkg.sv =====
package jfh_pkg;

   // Depth of each of the two queues in the block.
   localparam int QUEUE_DEPTH = 2;

   // Stream constants.
   localparam logic [15:0] SOI_WORD      = 16'hFFD8;
   localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
   localparam logic [7:0]  SOF0_CODE     = 8'hC0;
   localparam logic [7:0]  SOF1_CODE     = 8'hC1;
   localparam logic [7:0]  SOF3_CODE     = 8'hC3;

   // Frame modes as reported on the result channel.
   localparam logic [1:0] MODE_UNKNOWN  = 2'd0;
   localparam logic [1:0] MODE_BASELINE = 2'd1;
   localparam logic [1:0] MODE_EXTENDED = 2'd2;
   localparam logic [1:0] MODE_LOSSLESS = 2'd3;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_SOI   = 3'd1,
      ST_BAD_PREF = 3'd2,
      ST_UNSUP    = 3'd3,
      ST_TRUNC    = 3'd4
   } jfh_status_type;

   // Class of a byte when it is read as a marker code.
   typedef enum logic [1:0] {
      MC_PLAIN  = 2'd0,
      MC_SOF    = 2'd1,
      MC_UNSUP  = 2'd2,
      MC_LENGTH = 2'd3
   } jfh_mcls_type;

   typedef enum logic [3:0] {
      PH_SOI0    = 4'd0,
      PH_SOI1    = 4'd1,
      PH_MARK0   = 4'd2,
      PH_MARK1   = 4'd3,
      PH_LEN0    = 4'd4,
      PH_LEN1    = 4'd5,
      PH_SKIP    = 4'd6,
      PH_SOF     = 4'd7,
      PH_DISCARD = 4'd8
   } jfh_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } jfh_req_type;

   // A classified byte as it waits between the front and the back.
   typedef struct packed {
      logic [7:0]   data_byte;
      logic         last_byte;
      jfh_mcls_type mclass;
      logic [1:0]   sof_mode;
   } jfh_item_type;

   typedef struct packed {
      logic [1:0]     mode;
      logic [7:0]     precision;
      logic [15:0]    rows;
      logic [15:0]    columns;
      logic [7:0]     components;
      jfh_status_type status;
   } jfh_rsp_type;

endpackage

// ===== design/jfh_fifo.sv =====
module jfh_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/jfh_front.sv =====
module jfh_front (
   input  logic                 req_push,
   input  jfh_pkg::jfh_req_type req_data,
   output logic                 req_full,
   input  logic                 q_full,
   output logic                 q_push,
   output jfh_pkg::jfh_item_type q_item
);

   import jfh_pkg::*;

   localparam logic [7:0] SOF_LOW  = 8'hC2;
   localparam logic [7:0] SOF_HIGH = 8'hCF;
   localparam logic [7:0] DHT_CODE = 8'hC4;
   localparam logic [7:0] DAC_CODE = 8'hCC;
   localparam logic [7:0] COM_CODE = 8'hFE;
   localparam logic [7:0] SEG_LOW  = 8'hDA;
   localparam logic [7:0] SEG_HIGH = 8'hEF;

   logic [7:0] b;

   assign b        = req_data.data_byte;
   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   // Every byte is classified as if it were a marker code; the back uses the
   // class only when it is expecting one.
   always_comb begin
      q_item.data_byte = b;
      q_item.last_byte = req_data.last_byte;
      q_item.sof_mode  = MODE_UNKNOWN;
      q_item.mclass    = MC_PLAIN;
      priority if (b == SOF0_CODE) begin
         q_item.mclass   = MC_SOF;
         q_item.sof_mode = MODE_BASELINE;
      end else if (b == SOF1_CODE) begin
         q_item.mclass   = MC_SOF;
         q_item.sof_mode = MODE_EXTENDED;
      end else if (b == SOF3_CODE) begin
         q_item.mclass   = MC_SOF;
         q_item.sof_mode = MODE_LOSSLESS;
      end else if (b == DHT_CODE || b == DAC_CODE || b == COM_CODE ||
                   (b >= SEG_LOW && b <= SEG_HIGH)) begin
         q_item.mclass = MC_LENGTH;
      end else if (b >= SOF_LOW && b <= SOF_HIGH) begin
         q_item.mclass = MC_UNSUP;
      end else begin
         q_item.mclass = MC_PLAIN;
      end
   end

endmodule

// ===== design/jfh_back.sv =====
module jfh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  jfh_pkg::jfh_item_type item,
   input  logic                  item_valid,
   output logic                  item_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output jfh_pkg::jfh_rsp_type  rsp_item
);

   import jfh_pkg::*;

   // Byte positions inside the frame header, counted from the length field.
   localparam logic [2:0] FLD_PREC    = 3'd2;
   localparam logic [2:0] FLD_ROWS_HI = 3'd3;
   localparam logic [2:0] FLD_ROWS_LO = 3'd4;
   localparam logic [2:0] FLD_COLS_HI = 3'd5;
   localparam logic [2:0] FLD_COLS_LO = 3'd6;
   localparam logic [2:0] FLD_COMPS   = 3'd7;

   jfh_phase_type  phase_ff, phase_in;
   logic [15:0]    skip_ff, skip_in, skip_upd;
   logic [7:0]     len_hi_ff, len_hi_in, len_hi_upd;
   logic [2:0]     field_ff, field_in, field_upd;
   logic [1:0]     mode_ff, mode_in, mode_upd;
   logic [7:0]     prec_ff, prec_in, prec_upd;
   logic [15:0]    rows_ff, rows_in, rows_upd;
   logic [15:0]    cols_ff, cols_in, cols_upd;
   logic [7:0]     comps_ff, comps_in, comps_upd;

   logic           fire;
   logic           last;
   logic [7:0]     b;
   logic [15:0]    seg_len;
   logic           res_valid;
   jfh_status_type res_status;

   assign b        = item.data_byte;
   assign last     = item.last_byte;
   assign seg_len  = {len_hi_ff, b};
   assign fire     = item_valid & ~rsp_full;
   assign item_pop = fire;

   // Result decision and field updates.
   always_comb begin
      len_hi_upd = len_hi_ff;
      skip_upd   = skip_ff;
      field_upd  = field_ff;
      mode_upd   = mode_ff;
      prec_upd   = prec_ff;
      rows_upd   = rows_ff;
      cols_upd   = cols_ff;
      comps_upd  = comps_ff;
      res_valid  = 1'b0;
      res_status = ST_OK;
      unique case (phase_ff)
         PH_SOI0: begin
            len_hi_upd = b;
         end
         PH_SOI1: begin
            if (seg_len != SOI_WORD) begin
               res_valid  = 1'b1;
               res_status = ST_NO_SOI;
            end
         end
         PH_MARK0: begin
            if (b != MARKER_PREFIX) begin
               res_valid  = 1'b1;
               res_status = ST_BAD_PREF;
            end
         end
         PH_MARK1: begin
            if (item.mclass == MC_SOF) begin
               mode_upd  = item.sof_mode;
               field_upd = '0;
            end else if (item.mclass == MC_UNSUP) begin
               res_valid  = 1'b1;
               res_status = ST_UNSUP;
            end
         end
         PH_LEN0: begin
            len_hi_upd = b;
         end
         PH_LEN1: begin
            skip_upd = (seg_len >= 16'd2) ? seg_len - 16'd2 : '0;
         end
         PH_SKIP: begin
            skip_upd = skip_ff - 16'd1;
         end
         PH_SOF: begin
            unique case (field_ff)
               FLD_PREC:    prec_upd  = b;
               FLD_ROWS_HI: rows_upd  = {b, 8'h00};
               FLD_ROWS_LO: rows_upd  = rows_ff | {8'h00, b};
               FLD_COLS_HI: cols_upd  = {b, 8'h00};
               FLD_COLS_LO: cols_upd  = cols_ff | {8'h00, b};
               FLD_COMPS:   comps_upd = b;
               default: ;
            endcase
            if (field_ff == FLD_COMPS) begin
               field_upd = '0;
               if (prec_ff != '0) begin
                  res_valid  = 1'b1;
                  res_status = ST_OK;
               end
            end else begin
               field_upd = field_ff + 3'd1;
            end
         end
         default: ;
      endcase
      // A last byte that ends nothing reports truncation, except while discarding.
      if (!res_valid && last && phase_ff != PH_DISCARD) begin
         res_valid  = 1'b1;
         res_status = ST_TRUNC;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (last) begin
         phase_in = PH_SOI0;
      end else if (res_valid) begin
         phase_in = PH_DISCARD;
      end else begin
         unique case (phase_ff)
            PH_SOI0:  phase_in = PH_SOI1;
            PH_SOI1:  phase_in = PH_MARK0;
            PH_MARK0: phase_in = PH_MARK1;
            PH_MARK1: begin
               unique case (item.mclass)
                  MC_SOF:    phase_in = PH_SOF;
                  MC_LENGTH: phase_in = PH_LEN0;
                  MC_PLAIN:  phase_in = PH_MARK0;
                  MC_UNSUP:  phase_in = PH_DISCARD;
               endcase
            end
            PH_LEN0:  phase_in = PH_LEN1;
            PH_LEN1:  phase_in = (seg_len > 16'd2) ? PH_SKIP : PH_MARK0;
            PH_SKIP:  phase_in = (skip_ff == 16'd1) ? PH_MARK0 : PH_SKIP;
            PH_SOF:   phase_in = (field_ff == FLD_COMPS) ? PH_MARK0 : PH_SOF;
            default:  phase_in = PH_DISCARD;
         endcase
      end
   end

   // The end of a buffer returns every field to its reset value.
   assign len_hi_in = last ? '0 : len_hi_upd;
   assign skip_in   = last ? '0 : skip_upd;
   assign field_in  = last ? '0 : field_upd;
   assign mode_in   = last ? MODE_UNKNOWN : mode_upd;
   assign prec_in   = last ? '0 : prec_upd;
   assign rows_in   = last ? '0 : rows_upd;
   assign cols_in   = last ? '0 : cols_upd;
   assign comps_in  = last ? '0 : comps_upd;

   assign rsp_push            = fire & res_valid;
   assign rsp_item.mode       = mode_upd;
   assign rsp_item.precision  = prec_upd;
   assign rsp_item.rows       = rows_upd;
   assign rsp_item.columns    = cols_upd;
   assign rsp_item.components = comps_upd;
   assign rsp_item.status     = res_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SOI0;
         skip_ff   <= '0;
         len_hi_ff <= '0;
         field_ff  <= '0;
         mode_ff   <= MODE_UNKNOWN;
         prec_ff   <= '0;
         rows_ff   <= '0;
         cols_ff   <= '0;
         comps_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         len_hi_ff <= len_hi_in;
         field_ff  <= field_in;
         mode_ff   <= mode_in;
         prec_ff   <= prec_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         comps_ff  <= comps_in;
      end
   end

endmodule

// ===== design/jpeg_frame_header_scanner.sv =====
// Throughput: one byte per clock, sustained, as long as results are popped.
// Each byte is registered in the byte queue, and the result that it causes is
// registered in the result queue before it shows on the rsp_ ports.
// The back state register updates once per byte and sets that rate.
// Reset (synchronous, active high) empties both queues and returns the parser
// to waiting for the first start-of-image byte with all captured fields zero.
module jpeg_frame_header_scanner #(
   parameter int REQ_DEPTH = jfh_pkg::QUEUE_DEPTH,
   parameter int RSP_DEPTH = jfh_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  jfh_pkg::jfh_req_type req_data,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output jfh_pkg::jfh_rsp_type rsp_data
);

   import jfh_pkg::*;

   // The front classifies each byte as a possible marker code and pushes it
   // into the byte queue. The queue lets the front keep taking bytes while
   // the back waits for room in the result queue.
   logic         item_full;
   logic         item_push;
   jfh_item_type item_in;
   logic         item_empty;
   logic         item_pop;
   jfh_item_type item_out;

   // The back walks the marker structure and writes at most one result for
   // each byte it takes. The result queue holds results until they are popped,
   // so a stalled consumer stops byte transfers only once the result queue is full.
   logic         rsp_q_full;
   logic         rsp_q_push;
   jfh_rsp_type  rsp_q_item;

   jfh_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (item_full),
      .q_push   (item_push),
      .q_item   (item_in)
   );

   jfh_fifo #(
      .item_type (jfh_item_type),
      .DEPTH     (REQ_DEPTH)
   ) u_item_q (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_item (item_in),
      .full      (item_full),
      .pop       (item_pop),
      .pop_item  (item_out),
      .empty     (item_empty)
   );

   jfh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item_out),
      .item_valid (~item_empty),
      .item_pop   (item_pop),
      .rsp_full   (rsp_q_full),
      .rsp_push   (rsp_q_push),
      .rsp_item   (rsp_q_item)
   );

   jfh_fifo #(
      .item_type (jfh_rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_q_push),
      .push_item (rsp_q_item),
      .full      (rsp_q_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_data),
      .empty     (rsp_empty)
   );

   // A result is only ever written while a byte leaves the byte queue.
   a_rsp_needs_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_q_push |-> (item_pop && !item_empty))
      else $error("result written without a byte being consumed");

   // A frame result always carries a nonzero precision.
   a_ok_has_precision: assert property (@(posedge clock) disable iff (reset)
      (rsp_q_push && rsp_q_item.status == ST_OK) |-> (rsp_q_item.precision != 8'd0))
      else $error("ok result with zero precision");

   // The input side never reports full while the byte queue is empty.
   a_full_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      item_empty |-> !req_full)
      else $error("input full with an empty byte queue");

   // Reset leaves no result waiting.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting right after reset");

endmodule
